### rtl/core/sst_pkg.sv
// Shared types, widths and helpers for the SL(2,C) spinor transform core.
// No dependencies; every module of the core imports this package.
package sst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = DATA_W + 1;
  localparam int PROD_W    = COEF_W + DATA_W;
  localparam int SHP_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W     = SHP_W + 2;
  localparam int NUM_LANES = 4;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SHP_W-1:0]  shp_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam data_t FX_ONE   = data_t'(1) << FRAC_BITS;
  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_WEYL_L   = 2'd0,
    KIND_WEYL_R   = 2'd1,
    KIND_DIRAC    = 2'd2,
    KIND_MAJORANA = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_RE = 3'd0,
    REG_A_IM = 3'd1,
    REG_B_RE = 3'd2,
    REG_B_IM = 3'd3,
    REG_C_RE = 3'd4,
    REG_C_IM = 3'd5,
    REG_D_RE = 3'd6,
    REG_D_IM = 3'd7
  } cfg_idx_t;

  // One complex matrix row and one complex 2-vector.
  typedef struct packed {
    coef_t c0_re;
    coef_t c0_im;
    coef_t c1_re;
    coef_t c1_im;
  } mrow_t;

  typedef struct packed {
    data_t x0_re;
    data_t x0_im;
    data_t x1_re;
    data_t x1_im;
  } vec_t;

  typedef struct packed {
    data_t re;
    data_t im;
  } cplx_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } beat_ctl_t;

  typedef struct packed {
    kind_t kind;
    cplx_t c0;
    cplx_t c1;
    cplx_t c2;
    cplx_t c3;
  } res_t;

  function automatic coef_t ext_coef(input data_t d);
    ext_coef = coef_t'(d);
  endfunction

  // Exact negation: -(-2^31) stays positive in the wider coefficient.
  function automatic coef_t neg_coef(input data_t d);
    neg_coef = -coef_t'(d);
  endfunction

  function automatic data_t sat_data(input sum_t s);
    if (s > sum_t'(DATA_MAX)) begin
      sat_data = DATA_MAX;
    end else if (s < sum_t'(DATA_MIN)) begin
      sat_data = DATA_MIN;
    end else begin
      sat_data = s[DATA_W-1:0];
    end
  endfunction

endpackage

### rtl/core/sst_lane.sv
// One lane: a complex matrix row times a complex 2-vector, Q-format truncation,
// saturating sum. Two register stages. Depends on sst_pkg.
module sst_lane import sst_pkg::*; (
  input  logic  clk,
  input  mrow_t row,
  input  vec_t  vec,
  output cplx_t res
);

  shp_t  prod_r [8];
  shp_t  prod_nxt [8];
  prod_t full [8];
  sum_t  re_sum;
  sum_t  im_sum;
  cplx_t res_r;

  always_comb begin
    full[0] = prod_t'(row.c0_re) * prod_t'(vec.x0_re);
    full[1] = prod_t'(row.c0_im) * prod_t'(vec.x0_im);
    full[2] = prod_t'(row.c1_re) * prod_t'(vec.x1_re);
    full[3] = prod_t'(row.c1_im) * prod_t'(vec.x1_im);
    full[4] = prod_t'(row.c0_re) * prod_t'(vec.x0_im);
    full[5] = prod_t'(row.c0_im) * prod_t'(vec.x0_re);
    full[6] = prod_t'(row.c1_re) * prod_t'(vec.x1_im);
    full[7] = prod_t'(row.c1_im) * prod_t'(vec.x1_re);
    for (int i = 0; i < 8; i++) begin
      // drop fraction bits: arithmetic shift, rounds toward minus infinity
      prod_nxt[i] = full[i][PROD_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_comb begin
    re_sum = sum_t'(prod_r[0]) - sum_t'(prod_r[1])
           + sum_t'(prod_r[2]) - sum_t'(prod_r[3]);
    im_sum = sum_t'(prod_r[4]) + sum_t'(prod_r[5])
           + sum_t'(prod_r[6]) + sum_t'(prod_r[7]);
  end

  always_ff @(posedge clk) begin
    res_r.re <= sat_data(re_sum);
    res_r.im <= sat_data(im_sum);
  end

  assign res = res_r;

endmodule

### rtl/core/sst_merge.sv
// Merge stage: gathers the four lane results into one output beat and
// clears the upper components for Weyl kinds. Depends on sst_pkg.
module sst_merge import sst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  beat_ctl_t ctl,
  input  cplx_t     lane_res [NUM_LANES],
  output logic      vld,
  output res_t      res
);

  logic  vld_r;
  res_t  res_r;
  res_t  res_nxt;
  logic  weyl;

  always_comb begin
    weyl        = (ctl.kind == KIND_WEYL_L) || (ctl.kind == KIND_WEYL_R);
    res_nxt.kind = ctl.kind;
    res_nxt.c0   = lane_res[0];
    res_nxt.c1   = lane_res[1];
    res_nxt.c2   = weyl ? '0 : lane_res[2];
    res_nxt.c3   = weyl ? '0 : lane_res[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign vld = vld_r;
  assign res = res_r;

endmodule

### rtl/core/spinor_sl2c_transform_core.sv
// SL(2,C) spinor transform core: four lanes, one per output component.
// Registered in order: input, lane products, lane sums, merge output.
// Throughput: one spinor per cycle; busy stays low, so start may be high every cycle.
// Reset (rst_n low, synchronous) clears the pipeline valids and sets the matrix to identity.
// Results cannot be stalled; each is shown for one cycle with out_valid high.
module spinor_sl2c_transform_core import sst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_spinor_kind,
  input  logic signed [31:0]   in_in0_re,
  input  logic signed [31:0]   in_in0_im,
  input  logic signed [31:0]   in_in1_re,
  input  logic signed [31:0]   in_in1_im,
  input  logic signed [31:0]   in_in2_re,
  input  logic signed [31:0]   in_in2_im,
  input  logic signed [31:0]   in_in3_re,
  input  logic signed [31:0]   in_in3_im,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic signed [31:0]   out_out0_re,
  output logic signed [31:0]   out_out0_im,
  output logic signed [31:0]   out_out1_re,
  output logic signed [31:0]   out_out1_im,
  output logic signed [31:0]   out_out2_re,
  output logic signed [31:0]   out_out2_im,
  output logic signed [31:0]   out_out3_re,
  output logic signed [31:0]   out_out3_im
);

  // Matrix registers, plus the negated terms the right-handed matrix needs.
  data_t a_re_r, a_im_r, b_re_r, b_im_r, c_re_r, c_im_r, d_re_r, d_im_r;
  coef_t neg_a_im_r, neg_b_re_r, neg_c_re_r, neg_d_im_r;

  beat_ctl_t ctl_a_r, ctl_a_nxt, ctl_b_r, ctl_c_r;
  vec_t      lo_a_r, hi_a_r;

  mrow_t     m_row0, m_row1, r_row0, r_row1;
  mrow_t     lane_row [NUM_LANES];
  vec_t      lane_vec [NUM_LANES];
  cplx_t     lane_res [NUM_LANES];
  logic      mrg_vld;
  res_t      mrg_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_re_r     <= FX_ONE;
      a_im_r     <= '0;
      b_re_r     <= '0;
      b_im_r     <= '0;
      c_re_r     <= '0;
      c_im_r     <= '0;
      d_re_r     <= FX_ONE;
      d_im_r     <= '0;
      neg_a_im_r <= '0;
      neg_b_re_r <= '0;
      neg_c_re_r <= '0;
      neg_d_im_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_A_RE: a_re_r <= cfg_wdata;
        REG_A_IM: begin
          a_im_r     <= cfg_wdata;
          neg_a_im_r <= neg_coef(cfg_wdata);
        end
        REG_B_RE: begin
          b_re_r     <= cfg_wdata;
          neg_b_re_r <= neg_coef(cfg_wdata);
        end
        REG_B_IM: b_im_r <= cfg_wdata;
        REG_C_RE: begin
          c_re_r     <= cfg_wdata;
          neg_c_re_r <= neg_coef(cfg_wdata);
        end
        REG_C_IM: c_im_r <= cfg_wdata;
        REG_D_RE: d_re_r <= cfg_wdata;
        REG_D_IM: begin
          d_im_r     <= cfg_wdata;
          neg_d_im_r <= neg_coef(cfg_wdata);
        end
      endcase
    end
  end

  // Input stage: capture the beat on start.
  always_comb begin
    ctl_a_nxt.vld  = start && !busy;
    ctl_a_nxt.kind = kind_t'(in_spinor_kind);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
    end else begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_a_r <= '{x0_re: in_in0_re, x0_im: in_in0_im, x1_re: in_in1_re, x1_im: in_in1_im};
    hi_a_r <= '{x0_re: in_in2_re, x0_im: in_in2_im, x1_re: in_in3_re, x1_im: in_in3_im};
  end

  // M = [[a, b], [c, d]];  R = [[conj d, -conj c], [-conj b, conj a]]
  always_comb begin
    m_row0 = '{c0_re: ext_coef(a_re_r), c0_im: ext_coef(a_im_r),
               c1_re: ext_coef(b_re_r), c1_im: ext_coef(b_im_r)};
    m_row1 = '{c0_re: ext_coef(c_re_r), c0_im: ext_coef(c_im_r),
               c1_re: ext_coef(d_re_r), c1_im: ext_coef(d_im_r)};
    r_row0 = '{c0_re: ext_coef(d_re_r), c0_im: neg_d_im_r,
               c1_re: neg_c_re_r,       c1_im: ext_coef(c_im_r)};
    r_row1 = '{c0_re: neg_b_re_r,       c0_im: ext_coef(b_im_r),
               c1_re: ext_coef(a_re_r), c1_im: neg_a_im_r};

    if (ctl_a_r.kind == KIND_WEYL_R) begin
      lane_row[0] = r_row0;
      lane_row[1] = r_row1;
    end else begin
      lane_row[0] = m_row0;
      lane_row[1] = m_row1;
    end
    lane_row[2] = r_row0;
    lane_row[3] = r_row1;

    lane_vec[0] = lo_a_r;
    lane_vec[1] = lo_a_r;
    lane_vec[2] = hi_a_r;
    lane_vec[3] = hi_a_r;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sst_lane u_lane (
      .clk (clk),
      .row (lane_row[g]),
      .vec (lane_vec[g]),
      .res (lane_res[g])
    );
  end

  sst_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_c_r),
    .lane_res (lane_res),
    .vld      (mrg_vld),
    .res      (mrg_res)
  );

  assign out_valid   = mrg_vld;
  assign out_kind    = mrg_res.kind;
  assign out_out0_re = mrg_res.c0.re;
  assign out_out0_im = mrg_res.c0.im;
  assign out_out1_re = mrg_res.c1.re;
  assign out_out1_im = mrg_res.c1.im;
  assign out_out2_re = mrg_res.c2.re;
  assign out_out2_im = mrg_res.c2.im;
  assign out_out3_re = mrg_res.c3.re;
  assign out_out3_im = mrg_res.c3.im;

endmodule
